[design/dsgpm_pkg.sv]
`timescale 1ns / 1ps

package dsgpm_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int SMOOTH_SHIFT = 10;
    localparam int GAIN_W       = 20;
    localparam int PAN_W        = 16;
    localparam int ENV_W        = 17;
    localparam int STATE_W      = 32;
    localparam int FRAC_EXTRA   = 12;
    localparam int ROUND_SHIFT  = 16;

    // operand and product widths of the shared multiplier
    localparam int R_W    = SAMPLE_BITS + 8;
    localparam int OPB_W  = GAIN_W + 1;
    localparam int PROD_W = R_W + OPB_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + ENV_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * SAMPLE_BITS + 2 * GAIN_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * SAMPLE_BITS - 2 * GAIN_W;

    localparam int CFG_W     = GAIN_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_UPPER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOWER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_TO_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_TO_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_TO_LEFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_TO_RIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NATURAL_ENV    = 3'd6;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd65536;
    localparam logic [PAN_W-1:0]  PAN_RESET  = 16'd46341;
    localparam logic [ENV_W-1:0]  ENV_UNITY  = 17'd65536;

    // microcode
    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SMOOTH = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LAST   = 4'd10;

    localparam logic [1:0] A_SAMPLE_U = 2'd0;
    localparam logic [1:0] A_SAMPLE_L = 2'd1;
    localparam logic [1:0] A_RES_U    = 2'd2;
    localparam logic [1:0] A_RES_L    = 2'd3;

    localparam logic [2:0] B_GAIN_U = 3'd0;
    localparam logic [2:0] B_GAIN_L = 3'd1;
    localparam logic [2:0] B_ENV    = 3'd2;
    localparam logic [2:0] B_UL     = 3'd3;
    localparam logic [2:0] B_LL     = 3'd4;
    localparam logic [2:0] B_UR     = 3'd5;
    localparam logic [2:0] B_LR     = 3'd6;

    localparam logic [2:0] WB_NONE  = 3'd0;
    localparam logic [2:0] WB_RES_U = 3'd1;
    localparam logic [2:0] WB_RES_L = 3'd2;
    localparam logic [2:0] WB_ACC   = 3'd3;
    localparam logic [2:0] WB_LEFT  = 3'd4;
    localparam logic [2:0] WB_RIGHT = 3'd5;

    localparam logic [1:0] COND_NEXT     = 2'd0;
    localparam logic [1:0] COND_WAIT_IN  = 2'd1;
    localparam logic [1:0] COND_WAIT_OUT = 2'd2;

    typedef struct packed {
        logic              mul_en;
        logic [1:0]        a_sel;
        logic [2:0]        b_sel;
        logic [2:0]        wb;
        logic              smooth;
        logic [1:0]        cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    function automatic ctrl_t mk(input logic mul_en, input logic [1:0] a_sel,
                                 input logic [2:0] b_sel, input logic [2:0] wb,
                                 input logic smooth, input logic [1:0] cond,
                                 input logic [STEP_W-1:0] target);
        ctrl_t c;
        c.mul_en = mul_en;
        c.a_sel  = a_sel;
        c.b_sel  = b_sel;
        c.wb     = wb;
        c.smooth = smooth;
        c.cond   = cond;
        c.target = target;
        return c;
    endfunction

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        unique case (step)
            4'd0:    c = mk(1'b0, A_SAMPLE_U, B_GAIN_U, WB_NONE,  1'b0, COND_WAIT_IN,  STEP_IDLE);
            4'd1:    c = mk(1'b0, A_SAMPLE_U, B_GAIN_U, WB_NONE,  1'b1, COND_NEXT,     STEP_IDLE);
            4'd2:    c = mk(1'b1, A_SAMPLE_U, B_GAIN_U, WB_NONE,  1'b0, COND_NEXT,     STEP_IDLE);
            4'd3:    c = mk(1'b1, A_SAMPLE_L, B_GAIN_L, WB_RES_U, 1'b0, COND_NEXT,     STEP_IDLE);
            4'd4:    c = mk(1'b1, A_RES_U,    B_ENV,    WB_RES_L, 1'b0, COND_NEXT,     STEP_IDLE);
            4'd5:    c = mk(1'b1, A_RES_L,    B_ENV,    WB_RES_U, 1'b0, COND_NEXT,     STEP_IDLE);
            4'd6:    c = mk(1'b1, A_RES_U,    B_UL,     WB_RES_L, 1'b0, COND_NEXT,     STEP_IDLE);
            4'd7:    c = mk(1'b1, A_RES_L,    B_LL,     WB_ACC,   1'b0, COND_NEXT,     STEP_IDLE);
            4'd8:    c = mk(1'b1, A_RES_U,    B_UR,     WB_LEFT,  1'b0, COND_NEXT,     STEP_IDLE);
            4'd9:    c = mk(1'b1, A_RES_L,    B_LR,     WB_ACC,   1'b0, COND_NEXT,     STEP_IDLE);
            4'd10:   c = mk(1'b0, A_SAMPLE_U, B_GAIN_U, WB_RIGHT, 1'b0, COND_WAIT_OUT, STEP_IDLE);
            default: c = mk(1'b0, A_SAMPLE_U, B_GAIN_U, WB_NONE,  1'b0, COND_NEXT,     STEP_IDLE);
        endcase
        return c;
    endfunction

    function automatic logic [STATE_W-1:0] smooth_step(input logic [STATE_W-1:0] s,
                                                      input logic [GAIN_W-1:0] tgt);
        logic signed [STATE_W:0] d;
        logic signed [STATE_W:0] d_sh;
        d    = $signed({1'b0, tgt, {FRAC_EXTRA{1'b0}}}) - $signed({1'b0, s});
        d_sh = d >>> SMOOTH_SHIFT;
        return s + d_sh[STATE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed({{(SUM_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}});
        lo = ~hi;
        if (x > hi)
            return hi[SAMPLE_BITS-1:0];
        else if (x < lo)
            return lo[SAMPLE_BITS-1:0];
        else
            return x[SAMPLE_BITS-1:0];
    endfunction

endpackage

[design/dual_smoothed_gain_pan_mixer.sv]
`timescale 1ns / 1ps

// dual smoothed gain pan mixer
// input stream s_*: one frame per request, s_tdata = sample_upper, sample_lower,
// envelope_gain from the lowest bit up, s_tuser = key_on
// output stream m_*: one request per frame, m_tdata = out_left, out_right,
// smoothed_upper, smoothed_lower from the lowest bit up
// cfg_we / cfg_index / cfg_data write the seven gain, pan and mode registers;
// write them only while no frame is in flight
// a small microcode program drives one shared multiplier: one step takes the
// frame, one updates both smoothers, eight do the eight products, one rounds
// the right mix and loads the output register
// a new frame is taken only after the previous one has run through every step,
// since the eight products go through the single multiplier
// reset clears both smoothers, loads the register defaults and empties the
// output register
// when the receiver stalls, the finished result waits in the output register;
// the next frame is still taken and computed, then holds in its last step
// until the output register frees up
module dual_smoothed_gain_pan_mixer
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [dsgpm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dsgpm_pkg::CFG_W-1:0]            cfg_data,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // sample_upper, sample_lower, envelope_gain, zero fill
    input  logic [dsgpm_pkg::IN_TDATA_W-1:0]       s_tdata,
    // key_on
    input  logic                                   s_tuser,

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_left, out_right, smoothed_upper, smoothed_lower, then OUT_PAD_W bits of zero fill (none at these widths)
    output logic [dsgpm_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    localparam int SB = dsgpm_pkg::SAMPLE_BITS;

    // config registers
    logic [dsgpm_pkg::GAIN_W-1:0] tgt_u_reg;
    logic [dsgpm_pkg::GAIN_W-1:0] tgt_l_reg;
    logic [dsgpm_pkg::PAN_W-1:0]  ul_reg;
    logic [dsgpm_pkg::PAN_W-1:0]  ur_reg;
    logic [dsgpm_pkg::PAN_W-1:0]  ll_reg;
    logic [dsgpm_pkg::PAN_W-1:0]  lr_reg;
    logic                         nat_env_reg;

    // sequencer
    logic [dsgpm_pkg::STEP_W-1:0] step_reg;
    logic [dsgpm_pkg::STEP_W-1:0] step_next;
    dsgpm_pkg::ctrl_t             ctrl;
    logic                         out_free;
    logic                         out_load;

    // datapath
    logic signed [SB-1:0]                    su_reg;
    logic signed [SB-1:0]                    sl_reg;
    logic [dsgpm_pkg::ENV_W-1:0]             env_reg;
    logic                                    key_reg;
    logic [dsgpm_pkg::STATE_W-1:0]           sm_u_reg;
    logic [dsgpm_pkg::STATE_W-1:0]           sm_l_reg;
    logic [dsgpm_pkg::STATE_W-1:0]           base_u;
    logic [dsgpm_pkg::STATE_W-1:0]           base_l;
    logic signed [dsgpm_pkg::R_W-1:0]        ru_reg;
    logic signed [dsgpm_pkg::R_W-1:0]        rl_reg;
    logic signed [dsgpm_pkg::PROD_W-1:0]     prod_reg;
    logic signed [dsgpm_pkg::PROD_W-1:0]     acc_reg;
    logic signed [SB-1:0]                    left_reg;
    logic signed [dsgpm_pkg::R_W-1:0]        mul_a;
    logic signed [dsgpm_pkg::OPB_W-1:0]      mul_b;
    logic [dsgpm_pkg::ENV_W-1:0]             env_eff;
    logic signed [dsgpm_pkg::PROD_W-1:0]     prod_rnd;
    logic signed [dsgpm_pkg::SUM_W-1:0]      mix_sum;
    logic signed [dsgpm_pkg::SUM_W-1:0]      mix_rnd;
    logic signed [SB-1:0]                    mix_sat;

    logic                                    m_tvalid_reg;
    logic [dsgpm_pkg::OUT_TDATA_W-1:0]       m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_u_reg   <= dsgpm_pkg::GAIN_RESET;
            tgt_l_reg   <= dsgpm_pkg::GAIN_RESET;
            ul_reg      <= dsgpm_pkg::PAN_RESET;
            ur_reg      <= dsgpm_pkg::PAN_RESET;
            ll_reg      <= dsgpm_pkg::PAN_RESET;
            lr_reg      <= dsgpm_pkg::PAN_RESET;
            nat_env_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dsgpm_pkg::REG_TARGET_UPPER:   tgt_u_reg   <= cfg_data;
                dsgpm_pkg::REG_TARGET_LOWER:   tgt_l_reg   <= cfg_data;
                dsgpm_pkg::REG_UPPER_TO_LEFT:  ul_reg      <= cfg_data[dsgpm_pkg::PAN_W-1:0];
                dsgpm_pkg::REG_UPPER_TO_RIGHT: ur_reg      <= cfg_data[dsgpm_pkg::PAN_W-1:0];
                dsgpm_pkg::REG_LOWER_TO_LEFT:  ll_reg      <= cfg_data[dsgpm_pkg::PAN_W-1:0];
                dsgpm_pkg::REG_LOWER_TO_RIGHT: lr_reg      <= cfg_data[dsgpm_pkg::PAN_W-1:0];
                dsgpm_pkg::REG_NATURAL_ENV:    nat_env_reg <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    // control store and step counter
    assign ctrl     = dsgpm_pkg::ucode(step_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (ctrl.cond == dsgpm_pkg::COND_WAIT_OUT) && out_free;
    assign s_tready = (ctrl.cond == dsgpm_pkg::COND_WAIT_IN);

    always_comb
    begin
        unique case (ctrl.cond)
            dsgpm_pkg::COND_NEXT:
                step_next = step_reg + 1'b1;
            dsgpm_pkg::COND_WAIT_IN:
                step_next = s_tvalid ? step_reg + 1'b1 : step_reg;
            dsgpm_pkg::COND_WAIT_OUT:
                step_next = out_free ? ctrl.target : step_reg;
            default:
                step_next = dsgpm_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= dsgpm_pkg::STEP_IDLE;
        else
            step_reg <= step_next;
    end

    // frame capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            su_reg  <= s_tdata[SB-1:0];
            sl_reg  <= s_tdata[2*SB-1:SB];
            env_reg <= s_tdata[2*SB+dsgpm_pkg::ENV_W-1:2*SB];
            key_reg <= s_tuser;
        end
    end

    // smoothers
    assign base_u = key_reg ? '0 : sm_u_reg;
    assign base_l = key_reg ? '0 : sm_l_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_u_reg <= '0;
            sm_l_reg <= '0;
        end
        else if (ctrl.smooth)
        begin
            sm_u_reg <= dsgpm_pkg::smooth_step(base_u, tgt_u_reg);
            sm_l_reg <= dsgpm_pkg::smooth_step(base_l, tgt_l_reg);
        end
    end

    // shared multiplier
    assign env_eff = nat_env_reg ? dsgpm_pkg::ENV_UNITY : env_reg;

    always_comb
    begin
        unique case (ctrl.a_sel)
            dsgpm_pkg::A_SAMPLE_U: mul_a = dsgpm_pkg::R_W'(su_reg);
            dsgpm_pkg::A_SAMPLE_L: mul_a = dsgpm_pkg::R_W'(sl_reg);
            dsgpm_pkg::A_RES_U:    mul_a = ru_reg;
            dsgpm_pkg::A_RES_L:    mul_a = rl_reg;
            default:               mul_a = ru_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.b_sel)
            dsgpm_pkg::B_GAIN_U:
                mul_b = $signed({1'b0, sm_u_reg[dsgpm_pkg::STATE_W-1:dsgpm_pkg::FRAC_EXTRA]});
            dsgpm_pkg::B_GAIN_L:
                mul_b = $signed({1'b0, sm_l_reg[dsgpm_pkg::STATE_W-1:dsgpm_pkg::FRAC_EXTRA]});
            dsgpm_pkg::B_ENV:
                mul_b = $signed({{(dsgpm_pkg::OPB_W - dsgpm_pkg::ENV_W){1'b0}}, env_eff});
            dsgpm_pkg::B_UL:
                mul_b = $signed({{(dsgpm_pkg::OPB_W - dsgpm_pkg::PAN_W){1'b0}}, ul_reg});
            dsgpm_pkg::B_LL:
                mul_b = $signed({{(dsgpm_pkg::OPB_W - dsgpm_pkg::PAN_W){1'b0}}, ll_reg});
            dsgpm_pkg::B_UR:
                mul_b = $signed({{(dsgpm_pkg::OPB_W - dsgpm_pkg::PAN_W){1'b0}}, ur_reg});
            dsgpm_pkg::B_LR:
                mul_b = $signed({{(dsgpm_pkg::OPB_W - dsgpm_pkg::PAN_W){1'b0}}, lr_reg});
            default:
                mul_b = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            prod_reg <= dsgpm_pkg::PROD_W'(mul_a) * dsgpm_pkg::PROD_W'(mul_b);
    end

    // rounding and write-back
    assign prod_rnd = (prod_reg + $signed(dsgpm_pkg::PROD_W'(1) <<< (dsgpm_pkg::ROUND_SHIFT - 1)))
                      >>> dsgpm_pkg::ROUND_SHIFT;
    assign mix_sum  = dsgpm_pkg::SUM_W'(acc_reg) + dsgpm_pkg::SUM_W'(prod_reg);
    assign mix_rnd  = (mix_sum + $signed(dsgpm_pkg::SUM_W'(1) <<< (dsgpm_pkg::ROUND_SHIFT - 1)))
                      >>> dsgpm_pkg::ROUND_SHIFT;
    assign mix_sat  = dsgpm_pkg::sat_sample(mix_rnd);

    always_ff @(posedge clk)
    begin
        unique case (ctrl.wb)
            dsgpm_pkg::WB_RES_U: ru_reg   <= prod_rnd[dsgpm_pkg::R_W-1:0];
            dsgpm_pkg::WB_RES_L: rl_reg   <= prod_rnd[dsgpm_pkg::R_W-1:0];
            dsgpm_pkg::WB_ACC:   acc_reg  <= prod_reg;
            dsgpm_pkg::WB_LEFT:  left_reg <= mix_sat;
            default:             ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= {{dsgpm_pkg::OUT_PAD_W{1'b0}},
                            sm_l_reg[dsgpm_pkg::STATE_W-1:dsgpm_pkg::FRAC_EXTRA],
                            sm_u_reg[dsgpm_pkg::STATE_W-1:dsgpm_pkg::FRAC_EXTRA],
                            mix_sat, left_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= dsgpm_pkg::STEP_LAST)
        else $error("step counter out of program");

    a_accept_to_smooth: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (step_reg == dsgpm_pkg::STEP_SMOOTH))
        else $error("frame taken but smoother step not next");

    a_smoother_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != dsgpm_pkg::STEP_SMOOTH) |=> ($stable(sm_u_reg) && $stable(sm_l_reg)))
        else $error("smoother changed outside its step");

    a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) ##1 m_tvalid |-> ($past(step_reg) == dsgpm_pkg::STEP_LAST))
        else $error("output reloaded outside last step");
`endif

endmodule
